// ===== rtl/tpq_pkg.sv =====
// Shared codes and types for the three-level priority task queue.
`timescale 1ns / 1ps

package tpq_pkg;

   localparam int NUM_LEVELS = 3;

   // Request operation codes
   localparam logic [1:0] OP_ADD      = 2'd0;
   localparam logic [1:0] OP_REMOVE   = 2'd1;
   localparam logic [1:0] OP_ANNOUNCE = 2'd2;

   // Add level that names no queue
   localparam logic [1:0] LEVEL_INVALID = 2'd3;

   // Response kinds
   localparam logic [2:0] KIND_ADDED     = 3'd0;
   localparam logic [2:0] KIND_FULL      = 3'd1;
   localparam logic [2:0] KIND_BAD_LEVEL = 3'd2;
   localparam logic [2:0] KIND_REMOVED   = 3'd3;
   localparam logic [2:0] KIND_ANNOUNCED = 3'd4;
   localparam logic [2:0] KIND_NONE_LEFT = 3'd5;

   // Per-queue command: KEEP pops the head and appends it at the tail
   typedef enum logic [1:0] {
      ROW_HOLD,
      ROW_PUSH,
      ROW_POP,
      ROW_KEEP
   } row_cmd_type;

   // Per-cell control
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

// ===== rtl/three_level_priority_task_queue.sv =====
// Top level: request sequencer over three queue rows (high, medium, low priority).
//
// Requests: drive req_* with start high; the item is taken at a clock edge where
// busy is low. busy stays high until the item's work is done.
// Responses: each result shows on rsp_* for one cycle with rsp_valid high;
// rsp_last marks the final result of an item. The receiver cannot stall.
// Results per item:
//   add       : one result.
//   remove    : all three rows rotate their original cells once in parallel,
//               one entry per cycle, dropping matches; one result once the
//               fullest queue is through.
//   announce  : one pop and one result per cycle, up to the clamped count or
//               until the queues run dry; a single empty-queue result if all are empty.
//   other op, or announce with zero count: taken, no result.
// The last result of an item shows in the cycle after busy falls, and a new
// item may be taken in that cycle.
// Reset (synchronous, active high) empties all queues at once.
`timescale 1ns / 1ps

module three_level_priority_task_queue #(
   parameter int QUEUE_DEPTH  = 8,
   parameter int ID_WIDTH     = 16,
   parameter int MAX_ANNOUNCE = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [15:0] req_task_id,
   input  logic [1:0]  req_level,
   input  logic [4:0]  req_announce_count,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_out_task_id,
   output logic [1:0]  rsp_out_level,
   output logic [4:0]  rsp_removed_count,
   output logic        rsp_last
);
   import tpq_pkg::*;

   localparam int FILL_W = $clog2(QUEUE_DEPTH+1);
   localparam int TOT_W  = $clog2(NUM_LEVELS*QUEUE_DEPTH+1);
   localparam int CNT_W  = $clog2(MAX_ANNOUNCE+1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ADD,
      S_REMOVE,
      S_ANNOUNCE
   } state_type;

   state_type            state_ff, state_in;
   logic [ID_WIDTH-1:0]  id_ff, id_in;
   logic [1:0]           level_ff, level_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [FILL_W-1:0]    rem_ff [NUM_LEVELS];
   logic [FILL_W-1:0]    rem_in [NUM_LEVELS];
   logic [TOT_W-1:0]     removed_ff, removed_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_kind_ff, rsp_kind_in;
   logic [15:0]          rsp_id_ff, rsp_id_in;
   logic [1:0]           rsp_level_ff, rsp_level_in;
   logic [4:0]           rsp_removed_ff, rsp_removed_in;
   logic                 rsp_last_ff, rsp_last_in;

   row_cmd_type          cmd [NUM_LEVELS];
   logic [ID_WIDTH-1:0]  head [NUM_LEVELS];
   logic [FILL_W-1:0]    fill [NUM_LEVELS];
   logic [TOT_W-1:0]     total_fill;
   logic [1:0]           pick;
   logic [NUM_LEVELS-1:0] drop;
   logic                 ann_last;

   // queue rows
   for (genvar q = 0; q < NUM_LEVELS; q++) begin : g_row
      tpq_row #(
         .DEPTH (QUEUE_DEPTH),
         .WIDTH (ID_WIDTH)
      ) u_row (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd[q]),
         .push_data (id_ff),
         .head      (head[q]),
         .fill      (fill[q])
      );
   end

   // queue occupancy and highest nonempty level
   assign total_fill = TOT_W'(fill[0]) + TOT_W'(fill[1]) + TOT_W'(fill[2]);
   assign pick = (fill[0] != '0) ? 2'd0 : ((fill[1] != '0) ? 2'd1 : 2'd2);
   assign ann_last = (count_ff == CNT_W'(1)) || (total_fill == TOT_W'(1));

   // sequencer next state and response
   always_comb begin
      state_in       = state_ff;
      id_in          = id_ff;
      level_in       = level_ff;
      count_in       = count_ff;
      removed_in     = removed_ff;
      rsp_valid_in   = 1'b0;
      rsp_kind_in    = KIND_ADDED;
      rsp_id_in      = '0;
      rsp_level_in   = '0;
      rsp_removed_in = '0;
      rsp_last_in    = 1'b0;
      drop           = '0;
      for (int q = 0; q < NUM_LEVELS; q++) begin
         rem_in[q] = rem_ff[q];
         cmd[q]    = ROW_HOLD;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               id_in      = ID_WIDTH'(req_task_id);
               level_in   = req_level;
               removed_in = '0;
               count_in   = (req_announce_count > MAX_ANNOUNCE) ?
                            CNT_W'(MAX_ANNOUNCE) : CNT_W'(req_announce_count);
               for (int q = 0; q < NUM_LEVELS; q++) begin
                  rem_in[q] = fill[q];
               end
               case (req_op)
                  OP_ADD:      state_in = S_ADD;
                  OP_REMOVE:   state_in = S_REMOVE;
                  OP_ANNOUNCE: begin
                     if (req_announce_count != '0) begin
                        state_in = S_ANNOUNCE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_ADD: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            state_in     = S_IDLE;
            if (level_ff == LEVEL_INVALID) begin
               rsp_kind_in = KIND_BAD_LEVEL;
            end else if (fill[level_ff] == FILL_W'(QUEUE_DEPTH)) begin
               rsp_kind_in = KIND_FULL;
            end else begin
               rsp_kind_in   = KIND_ADDED;
               cmd[level_ff] = ROW_PUSH;
            end
         end

         S_REMOVE: begin
            // each row rotates its original entries once, dropping matches
            for (int q = 0; q < NUM_LEVELS; q++) begin
               if (rem_ff[q] != '0) begin
                  drop[q]   = (head[q] == id_ff);
                  cmd[q]    = drop[q] ? ROW_POP : ROW_KEEP;
                  rem_in[q] = rem_ff[q] - FILL_W'(1);
               end
            end
            removed_in = removed_ff + TOT_W'(drop[0]) + TOT_W'(drop[1]) + TOT_W'(drop[2]);
            if (rem_ff[0] == '0 && rem_ff[1] == '0 && rem_ff[2] == '0) begin
               rsp_valid_in   = 1'b1;
               rsp_last_in    = 1'b1;
               rsp_kind_in    = KIND_REMOVED;
               rsp_removed_in = 5'(removed_ff);
               state_in       = S_IDLE;
            end
         end

         S_ANNOUNCE: begin
            rsp_valid_in = 1'b1;
            if (total_fill == '0) begin
               // only reachable on the first cycle of an announce
               rsp_kind_in = KIND_NONE_LEFT;
               rsp_last_in = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd[pick]    = ROW_POP;
               rsp_kind_in  = KIND_ANNOUNCED;
               rsp_id_in    = 16'(head[pick]);
               rsp_level_in = pick;
               rsp_last_in  = ann_last;
               count_in     = count_ff - CNT_W'(1);
               if (ann_last) begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         id_ff          <= id_in;
         level_ff       <= level_in;
         count_ff       <= count_in;
         removed_ff     <= removed_in;
         for (int q = 0; q < NUM_LEVELS; q++) begin
            rem_ff[q] <= rem_in[q];
         end
         rsp_kind_ff    <= rsp_kind_in;
         rsp_id_ff      <= rsp_id_in;
         rsp_level_ff   <= rsp_level_in;
         rsp_removed_ff <= rsp_removed_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_out_task_id   = rsp_id_ff;
   assign rsp_out_level     = rsp_level_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_last          = rsp_last_ff;

   // a final result is never followed directly by another result
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result right after a final result");

   // once idle, any result still showing is the item's final one
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      !busy && rsp_valid |-> rsp_last)
      else $error("non-final result while idle");

   // each announced task leaves exactly one entry
   a_pop_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ANNOUNCED |-> total_fill + 1 == $past(total_fill))
      else $error("announce did not pop exactly one entry");

   // compaction never grows the queues
   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REMOVE |=> total_fill <= $past(total_fill))
      else $error("occupancy grew during remove");

endmodule

// ===== rtl/tpq_cell.sv =====
// One storage cell of a queue row: holds, loads, or takes its right neighbor.
`timescale 1ns / 1ps

module tpq_cell #(
   parameter int WIDTH = 16
) (
   input  logic                   clock,
   input  tpq_pkg::cell_ctrl_type ctrl,
   input  logic [WIDTH-1:0]       load_data,
   input  logic [WIDTH-1:0]       next_data,
   output logic [WIDTH-1:0]       data
);

   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in;

   // load wins over shift
   always_comb begin
      data_in = data_ff;
      if (ctrl.load) begin
         data_in = load_data;
      end else if (ctrl.shift) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== rtl/tpq_row.sv =====
// One FIFO queue built as a chain of cells shifting toward the head, with its fill count.
`timescale 1ns / 1ps

module tpq_row #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tpq_pkg::row_cmd_type         cmd,
   input  logic [WIDTH-1:0]             push_data,
   output logic [WIDTH-1:0]             head,
   output logic [$clog2(DEPTH+1)-1:0]   fill
);
   import tpq_pkg::*;

   localparam int FILL_W = $clog2(DEPTH+1);

   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [FILL_W-1:0] load_pos;
   logic              shift;
   logic              load;
   logic [WIDTH-1:0]  load_data;
   logic [WIDTH-1:0]  cell_data [DEPTH];
   cell_ctrl_type     ctrl [DEPTH];

   // decode the row command
   always_comb begin
      fill_in   = fill_ff;
      load_pos  = fill_ff;
      shift     = 1'b0;
      load      = 1'b0;
      load_data = push_data;
      case (cmd)
         ROW_PUSH: begin
            load    = 1'b1;
            fill_in = fill_ff + FILL_W'(1);
         end
         ROW_POP: begin
            shift   = 1'b1;
            fill_in = fill_ff - FILL_W'(1);
         end
         ROW_KEEP: begin
            // old head goes to the tail slot freed by the shift
            shift     = 1'b1;
            load      = 1'b1;
            load_pos  = fill_ff - FILL_W'(1);
            load_data = cell_data[0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // cell chain, cell 0 is the head
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WIDTH-1:0] next_data;

      if (i == DEPTH-1) begin : g_tail
         assign next_data = cell_data[i];
      end else begin : g_mid
         assign next_data = cell_data[i+1];
      end

      assign ctrl[i].shift = shift;
      assign ctrl[i].load  = load && (load_pos == FILL_W'(i));

      tpq_cell #(
         .WIDTH (WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl[i]),
         .load_data (load_data),
         .next_data (next_data),
         .data      (cell_data[i])
      );
   end

   assign head = cell_data[0];
   assign fill = fill_ff;

endmodule
